### rtl/core/prsi_pkg.sv
// Shared constants, types and command/status structs for the per-symbol RSI block.
// Used by the controller, datapath, divider and top level.
`default_nettype none
package prsi_pkg;

  localparam int NUM_SYMBOLS_DEF = 256;
  localparam int MAX_WINDOW_DEF  = 64;

  localparam int SYM_IN_W  = 8;
  localparam int PRICE_W   = 32;
  localparam int DAY_W     = 20;
  localparam int LEN_W     = 7;
  localparam int SUM_W     = 38;
  localparam int AVG_W     = 40;
  localparam int RSI_W     = 23;
  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 40;
  localparam int PROD_W    = SUM_W + LEN_W;

  localparam logic [LEN_W-1:0] WL_RESET  = 7'd14;
  localparam logic [LEN_W-1:0] RSI_SCALE = 7'd100;
  localparam logic [RSI_W-1:0] RSI_FULL  = 23'd6553600;

  typedef enum logic [1:0] {
    SEL_GAIN,
    SEL_LOSS,
    SEL_RSI
  } div_sel_e;

  typedef struct packed {
    logic     capture;
    logic     rec_load;
    logic     first_wr;
    logic     win_upd;
    logic     div_start;
    logic     div_store;
    div_sel_e div_sel;
    logic     rsi_direct;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic drop;
    logic first_or_zero;
    logic emit;
    logic loss_zero;
    logic div_busy;
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

### rtl/core/prsi_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module prsi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### rtl/core/prsi_divider.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on prsi_pkg for default widths.
`default_nettype none
module prsi_divider #(
  parameter int NUM_W = prsi_pkg::DIV_NUM_W,
  parameter int DEN_W = prsi_pkg::DIV_DEN_W
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  busy_o,
  output logic      [NUM_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             fits;

  assign rem_sh = {rem_q, quo_q[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_comb begin
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    if (start_i) begin
      cnt_d = CNT_W'(NUM_W);
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      quo_d = {quo_q[NUM_W-2:0], fits};
      rem_d = fits ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = cnt_q != '0;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

### rtl/core/prsi_datapath.sv
// Datapath: per-symbol record RAM, window RAM, sums, divider and output register.
// Depends on prsi_pkg, prsi_ram and prsi_divider.
`default_nettype none
module prsi_datapath #(
  parameter int NUM_SYMBOLS = prsi_pkg::NUM_SYMBOLS_DEF,
  parameter int MAX_WINDOW  = prsi_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [prsi_pkg::LEN_W-1:0]    cfg_wdata_i,
  input  wire logic                          in_valid_i,
  input  wire logic [prsi_pkg::SYM_IN_W-1:0] symbol_index_i,
  input  wire logic [prsi_pkg::PRICE_W-1:0]  close_price_i,
  input  wire logic [prsi_pkg::DAY_W-1:0]    trading_day_i,
  input  wire logic                          bar_valid_i,
  input  wire prsi_pkg::cmd_t                cmd_i,
  output prsi_pkg::status_t                  status_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [prsi_pkg::SYM_IN_W-1:0]      out_symbol_o,
  output logic [prsi_pkg::PRICE_W-1:0]       out_close_o,
  output logic [prsi_pkg::AVG_W-1:0]         average_gain_o,
  output logic [prsi_pkg::AVG_W-1:0]         average_loss_o,
  output logic [prsi_pkg::RSI_W-1:0]         rsi_value_o,
  output logic [prsi_pkg::DAY_W-1:0]         out_day_o
);
  import prsi_pkg::*;

  localparam int SYM_W   = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int SLOT_W  = $clog2(MAX_WINDOW);
  localparam int REC_W   = PRICE_W + LEN_W + SLOT_W + 2 * SUM_W;
  localparam int WIN_W   = 2 * PRICE_W;
  localparam int WADDR_W = SYM_W + SLOT_W;
  localparam int WDEPTH  = NUM_SYMBOLS * (2 ** SLOT_W);

  logic [LEN_W-1:0] wl_q;
  logic [LEN_W-1:0] len;

  logic [SYM_IN_W-1:0] sym_q;
  logic [PRICE_W-1:0]  close_q;
  logic [DAY_W-1:0]    day_q;

  logic [NUM_SYMBOLS-1:0] row_vld_q;
  logic [REC_W-1:0]       rec_rd, rec_wd;
  logic                   rec_we;
  logic [SYM_W-1:0]       sym_idx;

  logic                   rv;
  logic [PRICE_W-1:0]     lc_r;
  logic [LEN_W-1:0]       fill_r;
  logic [SLOT_W-1:0]      ws_r;
  logic [SUM_W-1:0]       gt_r, lt_r;
  logic [SLOT_W-1:0]      slot_c;
  logic                   full_c;

  logic [PRICE_W-1:0] gain_q, loss_q;
  logic [LEN_W-1:0]   fill_q, len_q;
  logic [SLOT_W-1:0]  ws_q, slot_q;
  logic [SUM_W-1:0]   gt_q, lt_q;
  logic               full_q;

  logic [WIN_W-1:0]   win_rd;
  logic [PRICE_W-1:0] old_g, old_l;
  logic [SUM_W-1:0]   gt_n, lt_n;
  logic [LEN_W-1:0]   fill_n;
  logic [SLOT_W-1:0]  ws_n;

  logic [PROD_W-1:0]    prod;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [DIV_NUM_W-1:0] quo;
  logic                 div_busy;
  logic [AVG_W-1:0]     quo_sat;

  logic [AVG_W-1:0] avg_g_q, avg_l_q;
  logic [RSI_W-1:0] rsi_q;
  logic             out_valid_q;

  assign len = (32'(wl_q) > MAX_WINDOW) ? LEN_W'(MAX_WINDOW) : wl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q <= WL_RESET;
    end else if (cfg_we_i) begin
      wl_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sym_q   <= symbol_index_i;
      close_q <= close_price_i;
      day_q   <= trading_day_i;
    end
  end

  assign sym_idx = SYM_W'(sym_q);

  prsi_ram #(.WIDTH(REC_W), .DEPTH(NUM_SYMBOLS), .ADDR_W(SYM_W)) u_rec_ram (
    .clk_i  (clk_i),
    .we_i   (rec_we),
    .waddr_i(sym_idx),
    .wdata_i(rec_wd),
    .re_i   (cmd_i.capture),
    .raddr_i(SYM_W'(symbol_index_i)),
    .rdata_o(rec_rd)
  );

  assign rv     = row_vld_q[sym_idx];
  assign lc_r   = rec_rd[REC_W-1 -: PRICE_W];
  assign fill_r = rv ? rec_rd[REC_W-PRICE_W-1 -: LEN_W] : '0;
  assign ws_r   = rv ? rec_rd[2*SUM_W+SLOT_W-1 -: SLOT_W] : '0;
  assign gt_r   = rv ? rec_rd[2*SUM_W-1 -: SUM_W] : '0;
  assign lt_r   = rv ? rec_rd[SUM_W-1:0] : '0;

  assign full_c = fill_r >= len;
  assign slot_c = !full_c ? SLOT_W'(fill_r) : ((32'(ws_r) < 32'(len)) ? ws_r : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (rec_we) begin
      row_vld_q[sym_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rec_load) begin
      gain_q <= (close_q > lc_r) ? close_q - lc_r : '0;
      loss_q <= (close_q < lc_r) ? lc_r - close_q : '0;
      fill_q <= fill_r;
      ws_q   <= ws_r;
      gt_q   <= gt_r;
      lt_q   <= lt_r;
      len_q  <= len;
      full_q <= full_c;
      slot_q <= slot_c;
    end else if (cmd_i.win_upd) begin
      gt_q <= gt_n;
      lt_q <= lt_n;
    end
  end

  prsi_ram #(.WIDTH(WIN_W), .DEPTH(WDEPTH), .ADDR_W(WADDR_W)) u_win_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.win_upd),
    .waddr_i({sym_idx, slot_q}),
    .wdata_i({gain_q, loss_q}),
    .re_i   (cmd_i.rec_load),
    .raddr_i({sym_idx, slot_c}),
    .rdata_o(win_rd)
  );

  assign old_g  = full_q ? win_rd[WIN_W-1 -: PRICE_W] : '0;
  assign old_l  = full_q ? win_rd[PRICE_W-1:0] : '0;
  assign gt_n   = gt_q - SUM_W'(old_g) + SUM_W'(gain_q);
  assign lt_n   = lt_q - SUM_W'(old_l) + SUM_W'(loss_q);
  assign fill_n = full_q ? fill_q : fill_q + 1'b1;
  assign ws_n   = !full_q ? ws_q
                : ((32'(slot_q) + 1 == 32'(len_q)) ? '0 : slot_q + 1'b1);

  assign rec_we = cmd_i.first_wr | cmd_i.win_upd;
  assign rec_wd = cmd_i.first_wr ? {close_q, fill_r, ws_r, gt_r, lt_r}
                                  : {close_q, fill_n, ws_n, gt_n, lt_n};

  assign prod = PROD_W'(gt_q) * PROD_W'(RSI_SCALE);

  always_comb begin
    unique case (cmd_i.div_sel)
      SEL_GAIN: begin
        div_num = DIV_NUM_W'({gt_q, 8'b0});
        div_den = DIV_DEN_W'(len_q);
      end
      SEL_LOSS: begin
        div_num = DIV_NUM_W'({lt_q, 8'b0});
        div_den = DIV_DEN_W'(len_q);
      end
      SEL_RSI: begin
        div_num = DIV_NUM_W'({prod, 16'b0});
        div_den = DIV_DEN_W'(gt_q) + DIV_DEN_W'(lt_q);
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  prsi_divider #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .quo_o  (quo)
  );

  assign quo_sat = (|quo[DIV_NUM_W-1:AVG_W]) ? '1 : quo[AVG_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_store) begin
      unique case (cmd_i.div_sel)
        SEL_GAIN: avg_g_q <= quo_sat;
        SEL_LOSS: avg_l_q <= quo_sat;
        SEL_RSI:  rsi_q   <= quo[RSI_W-1:0];
        default:  rsi_q   <= rsi_q;
      endcase
    end
    if (cmd_i.rsi_direct) begin
      rsi_q <= (gt_q != '0) ? RSI_FULL : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_symbol_o   <= sym_q;
      out_close_o    <= close_q;
      average_gain_o <= avg_g_q;
      average_loss_o <= avg_l_q;
      rsi_value_o    <= rsi_q;
      out_day_o      <= day_q;
    end
  end

  assign out_valid_o = out_valid_q;

  assign status_o.drop          = !in_valid_i || !bar_valid_i || trading_day_i[DAY_W-1]
                                  || (32'(symbol_index_i) >= NUM_SYMBOLS);
  assign status_o.first_or_zero = !rv || (len == '0);
  assign status_o.emit          = fill_n >= len_q;
  assign status_o.loss_zero     = lt_q == '0;
  assign status_o.div_busy      = div_busy;
  assign status_o.out_busy      = out_valid_q && out_stall_i;

endmodule
`default_nettype wire

### rtl/core/prsi_ctrl.sv
// Controller: sequences record lookup, window update, up to 3 divides, output load.
// Depends on prsi_pkg.
`default_nettype none
module prsi_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire prsi_pkg::status_t status_i,
  output prsi_pkg::cmd_t         cmd_o
);
  import prsi_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_REC  = 4'd1;
  localparam logic [3:0] S_WIN  = 4'd2;
  localparam logic [3:0] S_DG   = 4'd3;
  localparam logic [3:0] S_DGW  = 4'd4;
  localparam logic [3:0] S_DL   = 4'd5;
  localparam logic [3:0] S_DLW  = 4'd6;
  localparam logic [3:0] S_DR   = 4'd7;
  localparam logic [3:0] S_DRW  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.div_sel = SEL_GAIN;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && !status_i.drop) begin
          cmd_o.capture = 1'b1;
          state_d = S_REC;
        end
      end
      S_REC: begin
        if (status_i.first_or_zero) begin
          cmd_o.first_wr = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.rec_load = 1'b1;
          state_d = S_WIN;
        end
      end
      S_WIN: begin
        cmd_o.win_upd = 1'b1;
        state_d = status_i.emit ? S_DG : S_IDLE;
      end
      S_DG: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DGW;
      end
      S_DGW: begin
        if (!status_i.div_busy) begin
          cmd_o.div_store = 1'b1;
          state_d = S_DL;
        end
      end
      S_DL: begin
        cmd_o.div_sel = SEL_LOSS;
        cmd_o.div_start = 1'b1;
        state_d = S_DLW;
      end
      S_DLW: begin
        cmd_o.div_sel = SEL_LOSS;
        if (!status_i.div_busy) begin
          cmd_o.div_store = 1'b1;
          if (status_i.loss_zero) begin
            cmd_o.rsi_direct = 1'b1;
            state_d = S_OUT;
          end else begin
            state_d = S_DR;
          end
        end
      end
      S_DR: begin
        cmd_o.div_sel = SEL_RSI;
        cmd_o.div_start = 1'b1;
        state_d = S_DRW;
      end
      S_DRW: begin
        cmd_o.div_sel = SEL_RSI;
        if (!status_i.div_busy) begin
          cmd_o.div_store = 1'b1;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != S_IDLE;

endmodule
`default_nettype wire

### rtl/core/per_symbol_rsi_indicator.sv
// Top level of the per-symbol RSI block: controller plus datapath.
// Depends on prsi_pkg, prsi_ctrl and prsi_datapath.
//
// Input channel: in_valid_i / in_stall_o carry one price bar per word
// (symbol, close, day, bar flag). Output channel: out_valid_o / out_stall_i
// carry one result word (symbol, close, average gain, average loss, RSI, day).
// A word moves on a rising edge with valid high and stall low.
// Bars are handled one at a time. A dropped bar is discarded while idle;
// a first bar or a bar with zero window only writes its record; a bar that
// updates the window but gives no result passes the record and window
// states and returns to idle. A bar that gives a result goes through up to
// three 64-step radix-2 divides in one shared divider (two when the loss
// sum is zero) before the result is loaded into the output register.
// The output register lets the next bar be accepted while a result waits;
// a stalled receiver holds the result and the block stops before loading the
// next one. Reset clears the per-symbol valid bits at once, so no clearing
// pass is needed; window_length returns to 14. Write cfg_we_i only while idle.
`default_nettype none
module per_symbol_rsi_indicator #(
  parameter int NUM_SYMBOLS = prsi_pkg::NUM_SYMBOLS_DEF,
  parameter int MAX_WINDOW  = prsi_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [prsi_pkg::LEN_W-1:0]    cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [prsi_pkg::SYM_IN_W-1:0] symbol_index_i,
  input  wire logic [prsi_pkg::PRICE_W-1:0]  close_price_i,
  input  wire logic [prsi_pkg::DAY_W-1:0]    trading_day_i,
  input  wire logic                          bar_valid_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [prsi_pkg::SYM_IN_W-1:0]      out_symbol_o,
  output logic [prsi_pkg::PRICE_W-1:0]       out_close_o,
  output logic [prsi_pkg::AVG_W-1:0]         average_gain_o,
  output logic [prsi_pkg::AVG_W-1:0]         average_loss_o,
  output logic [prsi_pkg::RSI_W-1:0]         rsi_value_o,
  output logic [prsi_pkg::DAY_W-1:0]         out_day_o
);
  import prsi_pkg::*;

  cmd_t    cmd;
  status_t status;

  prsi_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  prsi_datapath #(.NUM_SYMBOLS(NUM_SYMBOLS), .MAX_WINDOW(MAX_WINDOW)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .symbol_index_i(symbol_index_i),
    .close_price_i (close_price_i),
    .trading_day_i (trading_day_i),
    .bar_valid_i   (bar_valid_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_symbol_o  (out_symbol_o),
    .out_close_o   (out_close_o),
    .average_gain_o(average_gain_o),
    .average_loss_o(average_loss_o),
    .rsi_value_o   (rsi_value_o),
    .out_day_o     (out_day_o)
  );

endmodule
`default_nettype wire

### rtl/core/prsi_checker.sv
// Port-level checks on the result channel of the per-symbol RSI block.
// Depends on prsi_pkg; bound to per_symbol_rsi_indicator.
`default_nettype none
module prsi_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic [prsi_pkg::SYM_IN_W-1:0] out_symbol_o,
  input wire logic [prsi_pkg::AVG_W-1:0]    average_gain_o,
  input wire logic [prsi_pkg::AVG_W-1:0]    average_loss_o,
  input wire logic [prsi_pkg::RSI_W-1:0]    rsi_value_o
);
  import prsi_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_symbol_o)
      && $stable(rsi_value_o))
    else $error("stalled result word changed");

  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && average_loss_o == '0 && average_gain_o != '0
      |-> rsi_value_o == RSI_FULL)
    else $error("rsi not full with zero loss");

  a_no_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && average_gain_o == '0 |-> rsi_value_o == '0)
    else $error("rsi nonzero with zero gain");

endmodule

bind per_symbol_rsi_indicator prsi_checker u_prsi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .out_symbol_o  (out_symbol_o),
  .average_gain_o(average_gain_o),
  .average_loss_o(average_loss_o),
  .rsi_value_o   (rsi_value_o)
);
`default_nettype wire
